>>> sv/hmifr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package hmifr_pkg;

    // Word store depth and the index width that addresses it
    localparam int          MAX_WORDS   = 32;
    localparam int          IDX_W       = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
    localparam logic [7:0]  MAX_WORDS_B = 8'(MAX_WORDS);

    // Register reset values
    localparam logic [7:0]  HDR_FIRST_RST  = 8'd90;
    localparam logic [7:0]  HDR_SECOND_RST = 8'd165;
    localparam logic [7:0]  REPLY_CODE_RST = 8'd131;

    typedef logic [IDX_W-1:0] t_word_idx;

    typedef enum logic [1:0] {
        CFG_HEADER_FIRST    = 2'd0,
        CFG_HEADER_SECOND   = 2'd1,
        CFG_READ_REPLY_CODE = 2'd2,
        CFG_UNUSED          = 2'd3
    } t_cfg_index;

    typedef enum logic [1:0] {
        PH_HUNT_FIRST  = 2'd0,
        PH_HUNT_SECOND = 2'd1,
        PH_LENGTH      = 2'd2,
        PH_PAYLOAD     = 2'd3
    } t_phase;

    typedef enum logic [1:0] {
        SQ_IDLE = 2'd0,
        SQ_EVAL = 2'd1,
        SQ_READ = 2'd2,
        SQ_LOAD = 2'd3
    } t_seq_state;

    typedef struct packed {
        logic [7:0] header_first;
        logic [7:0] header_second;
    } t_hdr_cfg;

    typedef struct packed {
        logic [7:0]  command;
        logic [15:0] start_address;
        logic [7:0]  word_total;
        logic [7:0]  bytes_taken;
    } t_frame_info;

endpackage

`default_nettype wire

>>> sv/hmi_frame_receiver.sv
// A received byte is taken while the sequencer is idle; mid-frame bytes stream at one per cycle.
// After the byte that ends a frame, an evaluation state checks it; then each stored word
// passes a read state (store read) and a load state (output load, held on output stall)
// via the single read port and address adder. Input ready stays low after the frame's
// last byte until the last result is loaded, or until the frame is discarded unanswered.
// Reset (synchronous, active low) clears parser state, config and sequencer registers and the output valid.
`timescale 1ns / 1ps
`default_nettype none

module hmi_frame_receiver
    import hmifr_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [7:0]  i_cfg_data,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [7:0]  i_s_axis_tdata,   // [7:0] rx_byte
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic [31:0]      o_m_axis_tdata,   // [15:0] word_address, [31:16] word_value
    output logic             o_m_axis_tuser,   // [0] frame_dropped
    output logic             o_m_axis_tlast
);

    t_hdr_cfg    r_hdr;
    logic [7:0]  r_reply_code;

    t_seq_state  r_seq, n_seq;
    t_word_idx   r_idx, n_idx;

    logic        r_out_valid, n_out_valid;
    logic [31:0] r_out_data, n_out_data;
    logic        r_out_drop, n_out_drop;
    logic        r_out_last, n_out_last;

    logic        in_xfer;
    logic        frame_end;
    t_frame_info info;
    logic [15:0] rd_data;

    logic        out_free;
    logic        cmd_match;
    logic        bad_count;
    logic [9:0]  need_bytes;
    logic [7:0]  idx_ext;
    logic        is_last;
    logic        load_drop;
    logic        load_word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hdr.header_first  <= HDR_FIRST_RST;
            r_hdr.header_second <= HDR_SECOND_RST;
            r_reply_code        <= REPLY_CODE_RST;
        end else if (i_cfg_we) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_HEADER_FIRST:    r_hdr.header_first  <= i_cfg_data;
                CFG_HEADER_SECOND:   r_hdr.header_second <= i_cfg_data;
                CFG_READ_REPLY_CODE: r_reply_code        <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_s_axis_tready = (r_seq == SQ_IDLE);
    assign in_xfer         = i_s_axis_tvalid && o_s_axis_tready;

    hmifr_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_hdr       (r_hdr),
        .i_byte_valid(in_xfer),
        .i_byte      (i_s_axis_tdata),
        .o_frame_end (frame_end),
        .o_info      (info),
        .i_rd_idx    (r_idx),
        .o_rd_data   (rd_data)
    );

    assign out_free   = !r_out_valid || i_m_axis_tready;
    assign cmd_match  = (info.command == r_reply_code);
    assign need_bytes = {1'b0, info.word_total, 1'b0} + 10'd4;
    assign bad_count  = (info.bytes_taken < 8'd4) || (info.word_total > MAX_WORDS_B)
                     || (need_bytes > {2'b00, info.bytes_taken});
    assign idx_ext    = {{(8-IDX_W){1'b0}}, r_idx};
    assign is_last    = ((idx_ext + 8'd1) == info.word_total);
    assign load_drop  = (r_seq == SQ_EVAL) && cmd_match && bad_count && out_free;
    assign load_word  = (r_seq == SQ_LOAD) && out_free;

    always_comb begin
        n_seq = r_seq;
        case (r_seq)
            SQ_IDLE: begin
                if (in_xfer && frame_end) n_seq = SQ_EVAL;
            end
            SQ_EVAL: begin
                if (!cmd_match) begin
                    n_seq = SQ_IDLE;
                end else if (bad_count) begin
                    if (out_free) n_seq = SQ_IDLE;
                end else if (info.word_total == 8'd0) begin
                    n_seq = SQ_IDLE;
                end else begin
                    n_seq = SQ_READ;
                end
            end
            SQ_READ: begin
                n_seq = SQ_LOAD;
            end
            SQ_LOAD: begin
                if (out_free) n_seq = is_last ? SQ_IDLE : SQ_READ;
            end
            default: begin
                n_seq = SQ_IDLE;
            end
        endcase
    end

    always_comb begin
        n_idx       = r_idx;
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;
        n_out_drop  = r_out_drop;
        n_out_last  = r_out_last;
        if (r_seq == SQ_IDLE) n_idx = '0;
        if (r_out_valid && i_m_axis_tready) n_out_valid = 1'b0;
        if (load_drop) begin
            n_out_valid = 1'b1;
            n_out_data  = 32'd0;
            n_out_drop  = 1'b1;
            n_out_last  = 1'b1;
        end
        if (load_word) begin
            n_out_valid = 1'b1;
            n_out_data  = {rd_data, info.start_address + {8'd0, idx_ext}};
            n_out_drop  = 1'b0;
            n_out_last  = is_last;
            n_idx       = r_idx + t_word_idx'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq       <= SQ_IDLE;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_seq       <= n_seq;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_data <= n_out_data;
        r_out_drop <= n_out_drop;
        r_out_last <= n_out_last;
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = r_out_drop;
    assign o_m_axis_tlast  = r_out_last;

endmodule

`default_nettype wire

>>> sv/hmifr_parser.sv
`timescale 1ns / 1ps
`default_nettype none

module hmifr_parser
    import hmifr_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_hdr_cfg    i_hdr,
    input  wire logic        i_byte_valid,
    input  wire logic [7:0]  i_byte,
    output logic             o_frame_end,
    output t_frame_info      o_info,
    input  wire t_word_idx   i_rd_idx,
    output logic [15:0]      o_rd_data
);

    t_phase      r_phase, n_phase;
    logic [7:0]  r_frame_length, n_frame_length;
    logic [7:0]  r_bytes_taken, n_bytes_taken;
    logic [7:0]  r_command, n_command;
    logic [15:0] r_start, n_start;
    logic [7:0]  r_total, n_total;
    logic [7:0]  r_pending, n_pending;

    logic [15:0] r_store [MAX_WORDS];
    logic [15:0] r_rd_data;

    logic [7:0]  bt_inc;
    logic [7:0]  wr_full;
    logic        store_we;

    // bytes_taken saturates at 255
    assign bt_inc      = (r_bytes_taken == 8'hFF) ? 8'hFF : r_bytes_taken + 8'd1;
    assign o_frame_end = i_byte_valid && (r_phase == PH_PAYLOAD) && (bt_inc >= r_frame_length);

    // word index of a low byte: (k - 5) / 2
    assign wr_full  = (r_bytes_taken - 8'd5) >> 1;
    assign store_we = i_byte_valid && (r_phase == PH_PAYLOAD) && (r_bytes_taken > 8'd3)
                   && r_bytes_taken[0] && (wr_full < MAX_WORDS_B);

    always_comb begin
        n_phase = r_phase;
        if (i_byte_valid) begin
            case (r_phase)
                PH_HUNT_FIRST: begin
                    if (i_byte == i_hdr.header_first) n_phase = PH_HUNT_SECOND;
                end
                PH_HUNT_SECOND: begin
                    n_phase = (i_byte == i_hdr.header_second) ? PH_LENGTH : PH_HUNT_FIRST;
                end
                PH_LENGTH: begin
                    n_phase = PH_PAYLOAD;
                end
                PH_PAYLOAD: begin
                    if (bt_inc >= r_frame_length) n_phase = PH_HUNT_FIRST;
                end
                default: begin
                    n_phase = PH_HUNT_FIRST;
                end
            endcase
        end
    end

    always_comb begin
        n_frame_length = r_frame_length;
        n_bytes_taken  = r_bytes_taken;
        n_command      = r_command;
        n_start        = r_start;
        n_total        = r_total;
        n_pending      = r_pending;
        if (i_byte_valid && (r_phase == PH_LENGTH)) begin
            n_frame_length = i_byte;
            n_bytes_taken  = 8'd0;
        end
        if (i_byte_valid && (r_phase == PH_PAYLOAD)) begin
            n_bytes_taken = bt_inc;
            case (r_bytes_taken)
                8'd0: n_command = i_byte;
                8'd1: n_start   = {i_byte, r_start[7:0]};
                8'd2: n_start   = {r_start[15:8], i_byte};
                8'd3: n_total   = i_byte;
                default: begin
                    if (!r_bytes_taken[0]) n_pending = i_byte;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= PH_HUNT_FIRST;
            r_frame_length <= 8'd0;
            r_bytes_taken  <= 8'd0;
            r_command      <= 8'd0;
            r_start        <= 16'd0;
            r_total        <= 8'd0;
            r_pending      <= 8'd0;
        end else begin
            r_phase        <= n_phase;
            r_frame_length <= n_frame_length;
            r_bytes_taken  <= n_bytes_taken;
            r_command      <= n_command;
            r_start        <= n_start;
            r_total        <= n_total;
            r_pending      <= n_pending;
        end
    end

    always_ff @(posedge i_clk) begin
        if (store_we) r_store[wr_full[IDX_W-1:0]] <= {r_pending, i_byte};
        r_rd_data <= r_store[i_rd_idx];
    end

    assign o_rd_data            = r_rd_data;
    assign o_info.command       = r_command;
    assign o_info.start_address = r_start;
    assign o_info.word_total    = r_total;
    assign o_info.bytes_taken   = r_bytes_taken;

endmodule

`default_nettype wire

>>> sv/hmifr_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module hmifr_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_s_axis_tready,
    input wire logic        o_m_axis_tvalid,
    input wire logic        i_m_axis_tready,
    input wire logic [31:0] o_m_axis_tdata,
    input wire logic        o_m_axis_tuser,
    input wire logic        o_m_axis_tlast
);

    // reset empties the output register
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output valid after reset");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser)
            && $stable(o_m_axis_tlast))
        else $error("stalled result changed");

    // a dropped frame gives a single zero result
    a_drop_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser |-> o_m_axis_tlast && (o_m_axis_tdata == 32'd0))
        else $error("malformed drop result");

    // input stays blocked while a word burst is still in progress
    a_burst_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && i_m_axis_tready && !o_m_axis_tlast |-> !o_s_axis_tready)
        else $error("input ready during word burst");

endmodule

bind hmi_frame_receiver hmifr_checker u_hmifr_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_s_axis_tready(o_s_axis_tready),
    .o_m_axis_tvalid(o_m_axis_tvalid),
    .i_m_axis_tready(i_m_axis_tready),
    .o_m_axis_tdata (o_m_axis_tdata),
    .o_m_axis_tuser (o_m_axis_tuser),
    .o_m_axis_tlast (o_m_axis_tlast)
);

`default_nettype wire
